[hdl/hierarchical_bitmap_block_allocator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hierarchical bitmap block allocator
// Shared property forms with the clock and reset of the allocator.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define HIERARCHICAL_BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBBA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HBBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/hbba_pkg.sv]
// ----------------------------------------------------------------------------
// hbba_pkg
// Widths, codes, types and shape helpers of the hierarchical bitmap allocator.
// ----------------------------------------------------------------------------
package hbba_pkg;

	localparam int ADDR_W   = 18;
	localparam int CNT_W    = 19;
	localparam int WORD_W   = 64;
	localparam int BIT_W    = 6;
	localparam int LVL_W    = 2;
	localparam int MEM_AW   = 13;
	localparam int PFX_W    = 12;

	localparam logic [CNT_W-1:0] MAX_BLOCKS = 19'd262144;
	localparam logic [CNT_W-1:0] MIN_BLOCKS = 19'd2;
	localparam logic [CNT_W-1:0] ONE_LEVEL_MAX = 19'd64;
	localparam logic [CNT_W-1:0] TWO_LEVEL_MAX = 19'd4096;

	// Word layout: root at 0, middle level at 1..64, leaves at 65..4160.
	localparam logic [MEM_AW-1:0] MID_BASE  = 13'd1;
	localparam logic [MEM_AW-1:0] LEAF_BASE = 13'd65;
	localparam logic [MEM_AW-1:0] MEM_LAST  = 13'd4160;

	localparam logic OP_MARK = 1'b0;
	localparam logic OP_FIND = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] block_address;
		logic              mark_used;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  eff_count;
		logic [LVL_W-1:0]  leaf_level;
		logic [WORD_W-1:0] last_full;
		logic [MEM_AW-1:0] last_word;
	} shape_t;

	function automatic logic [MEM_AW-1:0] level_base(input logic [LVL_W-1:0] k);
		logic [MEM_AW-1:0] base;
		case (k)
			2'd0:    base = '0;
			2'd1:    base = MID_BASE;
			default: base = LEAF_BASE;
		endcase
		return base;
	endfunction

	function automatic shape_t shape_of(input logic [CNT_W-1:0] value);
		shape_t s;
		logic [BIT_W-1:0] rem;
		if (value < MIN_BLOCKS) begin
			s.eff_count = MIN_BLOCKS;
		end else if (value > MAX_BLOCKS) begin
			s.eff_count = MAX_BLOCKS;
		end else begin
			s.eff_count = value;
		end
		if (s.eff_count <= ONE_LEVEL_MAX) begin
			s.leaf_level = 2'd0;
		end else if (s.eff_count <= TWO_LEVEL_MAX) begin
			s.leaf_level = 2'd1;
		end else begin
			s.leaf_level = 2'd2;
		end
		rem = s.eff_count[BIT_W-1:0];
		if (rem == '0) begin
			s.last_full = '1;
		end else begin
			s.last_full = (64'd1 << rem) - 64'd1;
		end
		s.last_word = s.eff_count[CNT_W-1:BIT_W];
		return s;
	endfunction

endpackage

[hdl/hbba_lzd.sv]
// ----------------------------------------------------------------------------
// hbba_lzd
// Lowest zero bit detector for one 64-bit bitmap word.
// ----------------------------------------------------------------------------
module hbba_lzd
	import hbba_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	output logic [BIT_W-1:0]  idx,
	output logic              none
);

	always_comb begin
		idx  = '0;
		none = &word;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				idx = BIT_W'(i);
			end
		end
	end

endmodule

[hdl/hbba_engine.sv]
// ----------------------------------------------------------------------------
// hbba_engine
// Bitmap memory with the read-modify-write sequencer for mark and find.
// ----------------------------------------------------------------------------
module hbba_engine
	import hbba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  shape_t            shape,
	input  logic              clear_req,
	input  logic              start,
	input  item_t             item,
	output logic              busy,
	output logic              done,
	output logic [ADDR_W-1:0] free_block,
	output logic              none_free
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CLEAR  = 2'd1;
	localparam logic [1:0] ST_READ   = 2'd2;
	localparam logic [1:0] ST_MODIFY = 2'd3;

	logic [1:0]        state_q;
	logic [MEM_AW-1:0] clr_cnt_q;
	logic              op_q;
	logic              used_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [PFX_W-1:0]  prefix_q;
	logic              done_q;
	logic [ADDR_W-1:0] free_block_q;
	logic              none_free_q;

	logic [WORD_W-1:0] mem [0:MEM_LAST];
	logic [WORD_W-1:0] rdata_q;

	logic [LVL_W-1:0]  depth;
	logic [PFX_W-1:0]  mark_idx;
	logic [BIT_W-1:0]  bpos;
	logic [MEM_AW-1:0] word_addr;
	logic [WORD_W-1:0] onehot;
	logic [WORD_W-1:0] full_mask;
	logic [WORD_W-1:0] new_word;
	logic              mark_write;
	logic              mark_up;
	logic [BIT_W-1:0]  zero_idx;
	logic              word_full;
	logic [ADDR_W-1:0] child;
	logic [ADDR_W-1:0] child_span;
	logic              find_none;
	logic              find_last;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	// Distance of the current level from the leaves.
	assign depth = shape.leaf_level - lvl_q;

	always_comb begin
		case (depth)
			2'd0: begin
				mark_idx   = addr_q[ADDR_W-1:BIT_W];
				bpos       = addr_q[BIT_W-1:0];
				child_span = child;
			end
			2'd1: begin
				mark_idx   = {{BIT_W{1'b0}}, addr_q[ADDR_W-1:2*BIT_W]};
				bpos       = addr_q[2*BIT_W-1:BIT_W];
				child_span = child << BIT_W;
			end
			default: begin
				mark_idx   = '0;
				bpos       = addr_q[ADDR_W-1:2*BIT_W];
				child_span = child << (2 * BIT_W);
			end
		endcase
	end

	assign word_addr = level_base(lvl_q)
		+ ((op_q == OP_FIND) ? {1'b0, prefix_q} : {1'b0, mark_idx});

	// Mark: update one bit and decide whether the parent must change too.
	assign onehot    = 64'd1 << bpos;
	assign full_mask = (depth == 2'd0 && {1'b0, mark_idx} == shape.last_word)
		? shape.last_full : '1;
	assign new_word   = used_q ? (rdata_q | onehot) : (rdata_q & ~onehot);
	assign mark_write = rdata_q[bpos] != used_q;
	assign mark_up    = mark_write && (lvl_q != '0)
		&& (used_q ? (new_word == full_mask) : (rdata_q == full_mask));

	// Find: take the lowest zero bit and check the subtree is in range.
	hbba_lzd u_lzd (
		.word (rdata_q),
		.idx  (zero_idx),
		.none (word_full)
	);

	assign child     = {prefix_q, zero_idx};
	assign find_none = word_full || ({1'b0, child_span} >= shape.eff_count);
	assign find_last = find_none || (lvl_q == shape.leaf_level);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_addr;
		mem_wdata = new_word;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (state_q == ST_MODIFY && op_q == OP_MARK && mark_write) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[word_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clear_req) begin
				state_q   <= ST_CLEAR;
				clr_cnt_q <= '0;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						if (clr_cnt_q == MEM_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							clr_cnt_q <= clr_cnt_q + 1'b1;
						end
					end
					ST_IDLE: begin
						if (start) begin
							if (item.operation == OP_FIND) begin
								state_q <= ST_READ;
							end else if ({1'b0, item.block_address} < shape.eff_count) begin
								state_q <= ST_READ;
							end
						end
					end
					ST_READ: begin
						state_q <= ST_MODIFY;
					end
					ST_MODIFY: begin
						if (op_q == OP_FIND) begin
							if (find_last) begin
								state_q <= ST_IDLE;
								done_q  <= 1'b1;
							end else begin
								state_q <= ST_READ;
							end
						end else if (mark_up) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// Item and walk registers carry payload only.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q     <= item.operation;
			used_q   <= item.mark_used;
			addr_q   <= item.block_address;
			prefix_q <= '0;
			lvl_q    <= (item.operation == OP_FIND) ? '0 : shape.leaf_level;
		end else if (state_q == ST_MODIFY) begin
			if (op_q == OP_FIND) begin
				prefix_q <= child[PFX_W-1:0];
				lvl_q    <= lvl_q + 1'b1;
			end else begin
				lvl_q <= lvl_q - 1'b1;
			end
		end
		if (state_q == ST_MODIFY && op_q == OP_FIND && find_last) begin
			free_block_q <= find_none ? '0 : child;
			none_free_q  <= find_none;
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = done_q;
	assign free_block = free_block_q;
	assign none_free  = none_free_q;

endmodule

[hdl/hierarchical_bitmap_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// hierarchical_bitmap_block_allocator_top
// Allocator over a 64-ary tree of bitmap words: marks blocks used or free and
// finds the lowest free block.
//
//   Channel  Direction  Signals                                   Transfer
//   command  in         start, busy, operation, block_address,    start & !busy
//                       mark_used
//   result   out        done, free_block, none_free               done
//   config   in         cfg_we, cfg_data                          cfg_we
//
// Every tree level visited takes a memory read followed by a modify and write-back
// step on the single bitmap RAM. A find walks one to three levels and shows its
// result in the first cycle with busy low. A mark climbs from the leaf for as long
// as fullness changes; a mark beyond the block count is taken with busy never rising.
// After reset and after every config write all 4161 words of the RAM are swept
// clear, one word a cycle, with busy high. Results cannot be held off.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_block_allocator_top
	import hbba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [ADDR_W-1:0] block_address,
	input  logic              mark_used,
	output logic              done,
	output logic [ADDR_W-1:0] free_block,
	output logic              none_free
);

	shape_t shape_q;
	item_t  item;

	// The tree shape is derived at reset and whenever the block count is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= shape_of(MAX_BLOCKS);
		end else if (cfg_we) begin
			shape_q <= shape_of(cfg_data);
		end
	end

	assign item.operation     = operation;
	assign item.block_address = block_address;
	assign item.mark_used     = mark_used;

	hbba_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.shape      (shape_q),
		.clear_req  (cfg_we),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.done       (done),
		.free_block (free_block),
		.none_free  (none_free)
	);

endmodule

[hdl/hbba_checker.sv]
// ----------------------------------------------------------------------------
// hbba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "hierarchical_bitmap_block_allocator_top_assert.svh"

module hbba_checker
	import hbba_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input logic [CNT_W-1:0]  cfg_data,
	input logic              start,
	input logic              busy,
	input logic              operation,
	input logic [ADDR_W-1:0] block_address,
	input logic              mark_used,
	input logic              done,
	input logic [ADDR_W-1:0] free_block,
	input logic              none_free
);

	// A config write always starts the clearing sweep.
	`HBBA_ASSERT_NEXT(a_cfg_clears, cfg_we, busy, "config write did not start clearing")

	// An accepted find raises busy in the next cycle.
	`HBBA_ASSERT_NEXT(a_find_busy, start && !busy && operation == OP_FIND, busy,
		"find transfer did not raise busy")

	// A result only follows a walk of the tree.
	`HBBA_ASSERT_SAME(a_done_after_walk, done, $past(busy), "result without a walk")

	// Two results never come in adjacent cycles.
	`HBBA_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted two cycles")

	// With no free block the block number reads zero.
	`HBBA_ASSERT_SAME(a_none_zero, done && none_free, free_block == '0,
		"none free with a nonzero block number")

endmodule

bind hierarchical_bitmap_block_allocator_top hbba_checker u_hbba_checker (.*);

[tb/hierarchical_bitmap_block_allocator_top_tb.sv]
// ----------------------------------------------------------------------------
// Testbench for hierarchical_bitmap_block_allocator_top
// Drives mark and find commands under several block counts, keeps its own copy
// of the bitmap tree to work out every find answer, and checks each result
// transfer against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_block_allocator_top_tb;
	import hbba_pkg::*;

	localparam int TREE_WORDS = 4161;
	localparam int SETTLE_CYCLES = 10;
	localparam int IDLE_PCT = 9;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam logic [WORD_W-1:0] ALL_SET = {WORD_W{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_FIELD_MAX = {CNT_W{1'b1}};
	localparam int unsigned ADDR_MAX = (1 << ADDR_W) - 1;

	typedef struct packed {
		logic [ADDR_W-1:0] free_block;
		logic              none_free;
	} find_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CNT_W-1:0]  cfg_data;
	logic              start;
	logic              busy;
	logic              operation;
	logic [ADDR_W-1:0] block_address;
	logic              mark_used;
	logic              done;
	logic [ADDR_W-1:0] free_block;
	logic              none_free;

	// Shadow copy of the tree and its shape.
	logic [WORD_W-1:0] tree_words [0:TREE_WORDS-1];
	int unsigned       live_count;
	int unsigned       tree_levels;

	find_result_t      pending_finds [$];
	int                mismatches;
	bit                gaps_on;

	hierarchical_bitmap_block_allocator_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.block_address (block_address),
		.mark_used     (mark_used),
		.done          (done),
		.free_block    (free_block),
		.none_free     (none_free)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned level_start(input int unsigned k);
		int unsigned p;
		p = 1;
		repeat (k) p = p * 64;
		return (p - 1) / 63;
	endfunction

	function automatic void tree_configure(input logic [CNT_W-1:0] value);
		int unsigned span;
		if (value < MIN_BLOCKS) begin
			live_count = MIN_BLOCKS;
		end else if (value > MAX_BLOCKS) begin
			live_count = MAX_BLOCKS;
		end else begin
			live_count = value;
		end
		tree_levels = 1;
		span = 1;
		while (span * 64 < live_count) begin
			span = span * 64;
			tree_levels++;
		end
		foreach (tree_words[i]) tree_words[i] = '0;
	endfunction

	function automatic void tree_mark(input logic [ADDR_W-1:0] addr, input logic used);
		int unsigned k, cur, w, rem;
		logic [WORD_W-1:0] bitm, old, full, partial;
		if (addr >= live_count) return;
		rem = live_count % 64;
		partial = (rem == 0) ? ALL_SET : ((64'd1 << rem) - 64'd1);
		k = tree_levels - 1;
		cur = addr;
		forever begin
			w = level_start(k) + cur / 64;
			bitm = 64'd1 << (cur % 64);
			old = tree_words[w];
			full = (k == tree_levels - 1 && cur / 64 == live_count / 64) ? partial : ALL_SET;
			if (((old & bitm) != '0) == used) break;
			if (used) begin
				tree_words[w] = old | bitm;
				if ((old | bitm) != full) break;
			end else begin
				// A word that was full loses its parent bit on any clear.
				tree_words[w] = old & ~bitm;
				if (old != full) break;
			end
			if (k == 0) break;
			k--;
			cur = cur / 64;
		end
	endfunction

	function automatic find_result_t tree_find();
		find_result_t r;
		longint unsigned pos, reach;
		int unsigned k, i;
		logic [WORD_W-1:0] m;
		r.free_block = '0;
		r.none_free = 1'b1;
		pos = 0;
		for (k = 0; k < tree_levels; k++) begin
			m = tree_words[level_start(k) + pos];
			reach = 1;
			repeat (tree_levels - 1 - k) reach = reach * 64;
			i = 0;
			while (i < 64 && m[i]) i++;
			if (i == 64) return r;
			pos = pos * 64 + i;
			// The chosen branch may hold no blocks below the count.
			if (pos * reach >= live_count) return r;
		end
		r.free_block = pos[ADDR_W-1:0];
		r.none_free = 1'b0;
		return r;
	endfunction

	function automatic void shuffle_blocks(ref int unsigned blocks [$]);
		int unsigned i, j, tmp;
		for (i = blocks.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = blocks[i];
			blocks[i] = blocks[j];
			blocks[j] = tmp;
		end
	endfunction

	// Presents one command and returns at the edge where it is transferred.
	task automatic issue_command(input logic op, input logic [ADDR_W-1:0] addr,
			input logic used);
		int unsigned gap;
		@(negedge clk);
		if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		operation <= op;
		block_address <= addr;
		mark_used <= used;
		do @(posedge clk); while (busy);
		if (op == OP_FIND) begin
			pending_finds.push_back(tree_find());
		end else begin
			tree_mark(addr, used);
		end
	endtask

	task automatic park_command();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_results_drained();
		park_command();
		while (pending_finds.size() != 0) @(posedge clk);
		// A trailing mark gives no result but may still be climbing the tree.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic wait_clear_sweep();
		do @(posedge clk); while (!busy);
		do @(posedge clk); while (busy);
	endtask

	task automatic write_block_count(input logic [CNT_W-1:0] value);
		wait_results_drained();
		while (busy) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		tree_configure(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		wait_clear_sweep();
	endtask

	task automatic test_reset_tree();
		issue_command(OP_FIND, '0, 1'b0);
		issue_command(OP_MARK, ADDR_W'(ADDR_MAX), 1'b1);
		issue_command(OP_MARK, '0, 1'b1);
		issue_command(OP_MARK, '0, 1'b1);
		issue_command(OP_FIND, '0, 1'b0);
		issue_command(OP_MARK, ADDR_W'(5), 1'b0);
		issue_command(OP_MARK, '0, 1'b0);
		issue_command(OP_FIND, ADDR_W'(ADDR_MAX), 1'b1);
	endtask

	task automatic test_count_extremes();
		write_block_count('0);
		issue_command(OP_MARK, '0, 1'b1);
		issue_command(OP_FIND, '0, 1'b0);
		issue_command(OP_MARK, ADDR_W'(1), 1'b1);
		issue_command(OP_FIND, '0, 1'b0);
		issue_command(OP_MARK, ADDR_W'(2), 1'b1);
		issue_command(OP_MARK, ADDR_W'(ADDR_MAX), 1'b1);
		issue_command(OP_MARK, ADDR_W'(1), 1'b0);
		issue_command(OP_FIND, '0, 1'b0);
		write_block_count(COUNT_FIELD_MAX);
		issue_command(OP_FIND, '0, 1'b0);
		// Last leaf word holds a single block.
		write_block_count(CNT_W'(65));
		issue_command(OP_MARK, ADDR_W'(64), 1'b1);
		issue_command(OP_FIND, '0, 1'b0);
		issue_command(OP_MARK, ADDR_W'(64), 1'b0);
		issue_command(OP_FIND, '0, 1'b0);
	endtask

	task automatic random_phase(input logic [CNT_W-1:0] value, input int unsigned budget);
		int unsigned sent, kind, chunk, top_chunk, lo, hi, i, window;
		int unsigned order [$];
		logic [ADDR_W-1:0] addr;
		write_block_count(value);
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				// Fill one low chunk of blocks in random order, finding now and then.
				top_chunk = (live_count - 1) / 64;
				chunk = $urandom_range(0, (top_chunk < 3) ? top_chunk : 3);
				lo = chunk * 64;
				hi = (lo + 64 < live_count) ? lo + 64 : live_count;
				order.delete();
				for (i = lo; i < hi; i++) order.push_back(i);
				shuffle_blocks(order);
				foreach (order[n]) begin
					if ($urandom_range(99) < 20) begin
						issue_command(OP_FIND, ADDR_W'($urandom), 1'($urandom));
						sent++;
					end
					issue_command(OP_MARK, ADDR_W'(order[n]), 1'b1);
					sent++;
				end
			end else if (kind < 85) begin
				window = (live_count < 256) ? live_count : 256;
				repeat (8) begin
					if ($urandom_range(99) < 30) begin
						issue_command(OP_FIND, ADDR_W'($urandom), 1'($urandom));
					end else begin
						addr = ADDR_W'($urandom_range(0, window - 1));
						issue_command(OP_MARK, addr, $urandom_range(99) < 40);
					end
					sent++;
				end
			end else begin
				repeat (5) begin
					if (live_count < MAX_BLOCKS && $urandom_range(1)) begin
						addr = ADDR_W'($urandom_range(live_count, ADDR_MAX));
						issue_command(OP_MARK, addr, 1'($urandom));
					end else begin
						addr = ADDR_W'($urandom_range(0, ADDR_MAX));
						issue_command(1'($urandom), addr, 1'($urandom));
					end
					sent++;
				end
			end
			if ($urandom_range(99) < 5) wait_results_drained();
		end
	endtask

	task automatic test_random_counts();
		random_phase(CNT_W'(1), 40);
		random_phase(CNT_W'(64), 80);
		random_phase(CNT_W'(100), 80);
		random_phase(CNT_W'($urandom_range(2, 300)), 70);
		random_phase(CNT_W'(4096), 70);
		gaps_on = 1'b0;
		random_phase(MAX_BLOCKS, 110);
		gaps_on = 1'b1;
		random_phase(CNT_W'($urandom_range(4097, 262144)), 60);
		random_phase(CNT_W'(130), 70);
	endtask

	// Fills the first leaf word of a three-level tree so that fullness climbs
	// to the middle level, then probes the branch that holds only one block.
	task automatic test_deep_fill();
		int unsigned order [$];
		int unsigned i, victim;
		write_block_count(CNT_W'(4097));
		for (i = 0; i < 64; i++) order.push_back(i);
		shuffle_blocks(order);
		foreach (order[n]) begin
			issue_command(OP_MARK, ADDR_W'(order[n]), 1'b1);
			if ($urandom_range(7) == 0) issue_command(OP_FIND, '0, 1'b0);
		end
		issue_command(OP_FIND, '0, 1'b0);
		issue_command(OP_MARK, ADDR_W'(4096), 1'b1);
		issue_command(OP_FIND, '0, 1'b0);
		victim = $urandom_range(0, 63);
		issue_command(OP_MARK, ADDR_W'(victim), 1'b0);
		issue_command(OP_FIND, '0, 1'b0);
		issue_command(OP_MARK, ADDR_W'(victim), 1'b1);
		issue_command(OP_MARK, ADDR_W'(4096), 1'b0);
		issue_command(OP_FIND, '0, 1'b0);
	endtask

	always @(posedge clk) begin
		find_result_t want;
		if (arst_n && done) begin
			if (pending_finds.size() == 0) begin
				$display("%0t: result transfer with none expected: free_block %0d none_free %0b",
					$time, free_block, none_free);
				mismatches++;
			end else begin
				want = pending_finds.pop_front();
				if (free_block !== want.free_block) begin
					$display("%0t: free_block expected %0d actual %0d",
						$time, want.free_block, free_block);
					mismatches++;
				end
				if (none_free !== want.none_free) begin
					$display("%0t: none_free expected %0b actual %0b",
						$time, want.none_free, none_free);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		operation = OP_MARK;
		block_address = '0;
		mark_used = 1'b0;
		mismatches = 0;
		gaps_on = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		tree_configure(MAX_BLOCKS);
		wait_clear_sweep();
		test_reset_tree();
		test_count_extremes();
		test_random_counts();
		test_deep_fill();
		wait_results_drained();
		if (mismatches == 0 && pending_finds.size() == 0) begin
			$display("hierarchical_bitmap_block_allocator_top: match");
		end else begin
			$display("hierarchical_bitmap_block_allocator_top: mismatch");
		end
		$finish;
	end

	initial begin
		#(20 * TIMEOUT_CYCLES);
		$display("hierarchical_bitmap_block_allocator_top: mismatch");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/hbba_pkg.sv
hdl/hbba_lzd.sv
hdl/hbba_engine.sv
hdl/hierarchical_bitmap_block_allocator_top.sv
hdl/hbba_checker.sv
tb/hierarchical_bitmap_block_allocator_top_tb.sv
